@@ rtl/core/bda_pkg.sv @@
// bda_pkg: shared types and constants for the binary to decimal ASCII converter.
// No dependencies.
package bda_pkg;

  localparam int MAX_DIGITS = 10;
  localparam int DEC_DIGITS = 10;   // decimal digits of a 32-bit value
  localparam int USABLE = (MAX_DIGITS > DEC_DIGITS) ? DEC_DIGITS :
                          ((MAX_DIGITS < 1) ? 1 : MAX_DIGITS);

  localparam int BIN_W   = 32;
  localparam int BCD_W   = 4 * DEC_DIGITS;
  localparam int CNT_W   = 4;       // digit_count, digit position, char count
  localparam int SHIFT_W = $clog2(BIN_W);
  localparam int CHAR_W  = 8;

  localparam logic [CNT_W-1:0]  USABLE_N = CNT_W'(USABLE);
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_PREP,
    S_EMIT
  } bda_state_e;

  typedef struct packed {
    logic load;
    logic shift;
    logic prep;
    logic emit;
  } bda_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic emit_last;
  } bda_status_t;

endpackage

@@ rtl/core/bda_ctrl.sv @@
// bda_ctrl: sequencing state machine of the converter.
// Depends on bda_pkg.
module bda_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  bda_pkg::bda_status_t status_i,
  output bda_pkg::bda_cmd_t  cmd_o,
  output logic               busy_o
);

  bda_pkg::bda_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bda_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      bda_pkg::S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = bda_pkg::S_CONV;
        end
      end
      bda_pkg::S_CONV: begin
        cmd_o.shift = 1'b1;
        if (status_i.conv_done) state_d = bda_pkg::S_PREP;
      end
      bda_pkg::S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = bda_pkg::S_EMIT;
      end
      bda_pkg::S_EMIT: begin
        cmd_o.emit = 1'b1;
        if (status_i.emit_last) state_d = bda_pkg::S_IDLE;
      end
      default: state_d = bda_pkg::S_IDLE;
    endcase
  end

endmodule

@@ rtl/core/bda_datapath.sv @@
// bda_datapath: shift-add-3 binary to BCD converter, width/overflow logic
// and registered character output. Depends on bda_pkg.
module bda_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bda_pkg::bda_cmd_t                cmd_i,
  input  logic [bda_pkg::BIN_W-1:0]        value_i,
  input  logic [bda_pkg::CNT_W-1:0]        digit_count_i,
  input  logic                             pad_with_zero_i,
  output bda_pkg::bda_status_t             status_o,
  output logic                             char_valid_o,
  output logic [bda_pkg::CHAR_W-1:0]       char_code_o,
  output logic                             last_o,
  output logic                             overflow_o
);

  logic [bda_pkg::BIN_W-1:0]   bin_q;
  logic [bda_pkg::BCD_W-1:0]   bcd_q, bcd_adj;
  logic [bda_pkg::SHIFT_W-1:0] shift_cnt_q;
  logic [bda_pkg::CNT_W-1:0]   cnt_q, top_q, pos_q;
  logic                        fixed_q, ovf_q;
  logic                        valid_q;
  logic [bda_pkg::CHAR_W-1:0]  char_q;
  logic                        last_q, ovf_out_q;

  logic [bda_pkg::CNT_W-1:0]   top_c, n_c;
  logic                        ovf_c, fixed_c;
  logic [3:0]                  dig_c;
  logic                        pad_c;
  logic [bda_pkg::CHAR_W-1:0]  char_c;

  // add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < bda_pkg::DEC_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                     : bcd_q[4*i +: 4];
    end
  end

  // highest nonzero digit, character count and overflow
  always_comb begin
    top_c = '0;
    for (int i = 0; i < bda_pkg::DEC_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] != 4'd0) top_c = bda_pkg::CNT_W'(i);
    end
    fixed_c = (cnt_q != '0);
    ovf_c   = 1'b0;
    if (fixed_c) begin
      n_c   = (cnt_q > bda_pkg::USABLE_N) ? bda_pkg::USABLE_N : cnt_q;
      ovf_c = (top_c >= n_c);
    end else if (top_c >= bda_pkg::USABLE_N) begin
      n_c   = bda_pkg::USABLE_N;
      ovf_c = 1'b1;
    end else begin
      n_c = top_c + 1'b1;
    end
  end

  // character at digit position pos_q
  always_comb begin
    dig_c  = bcd_q[4*pos_q +: 4];
    pad_c  = fixed_q && (pos_q > top_q) && (pos_q != '0);
    if (pad_c) begin
      char_c = pad_with_zero_i ? bda_pkg::CH_ZERO : bda_pkg::CH_SPACE;
    end else begin
      char_c = bda_pkg::CH_ZERO + {4'd0, dig_c};
    end
  end

  assign status_o.conv_done = (shift_cnt_q == bda_pkg::SHIFT_W'(bda_pkg::BIN_W - 1));
  assign status_o.emit_last = (pos_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      shift_cnt_q <= '0;
    end else begin
      valid_q <= cmd_i.emit;
      if (cmd_i.load) begin
        shift_cnt_q <= '0;
      end else if (cmd_i.shift) begin
        shift_cnt_q <= shift_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bin_q <= value_i;
      bcd_q <= '0;
      cnt_q <= digit_count_i;
    end else if (cmd_i.shift) begin
      bcd_q <= {bcd_adj[bda_pkg::BCD_W-2:0], bin_q[bda_pkg::BIN_W-1]};
      bin_q <= {bin_q[bda_pkg::BIN_W-2:0], 1'b0};
    end
    if (cmd_i.prep) begin
      top_q   <= top_c;
      fixed_q <= fixed_c;
      ovf_q   <= ovf_c;
      pos_q   <= n_c - 1'b1;
    end else if (cmd_i.emit) begin
      pos_q <= pos_q - 1'b1;
    end
    if (cmd_i.emit) begin
      char_q    <= char_c;
      last_q    <= status_o.emit_last;
      ovf_out_q <= ovf_q;
    end
  end

  assign char_valid_o = valid_q;
  assign char_code_o  = char_q;
  assign last_o       = last_q;
  assign overflow_o   = ovf_out_q;

endmodule

@@ rtl/core/binary_to_decimal_ascii_top.sv @@
// binary_to_decimal_ascii_top: top level of the binary to decimal ASCII converter.
// Depends on bda_pkg, bda_ctrl and bda_datapath.
//
// Channel   Direction  Handshake                  Payload
// command   in         start_i & !busy_o          value_i, digit_count_i
// result    out        char_valid_o (one cycle)   char_code_o, last_o, overflow_o
// config    in         cfg_valid_i & cfg_ready_o  cfg_pad_with_zero_i
//
// A conversion of 1 to 10 characters loads the value, runs the shift-add-3 loop (one shift
// per input bit) and sizes the field, then emits one character per cycle. busy_o falls
// once the last character is registered, so a new transaction can be taken in the cycle
// that shows the last character.
// Reset is asynchronous, active low, and clears the sequencer, the output strobe and the
// pad setting. Results cannot be stalled; config is always ready.
module binary_to_decimal_ascii_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // command
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [bda_pkg::BIN_W-1:0]    value_i,
  input  logic [bda_pkg::CNT_W-1:0]    digit_count_i,
  // result
  output logic                         char_valid_o,
  output logic [bda_pkg::CHAR_W-1:0]   char_code_o,
  output logic                         last_o,
  output logic                         overflow_o,
  // config
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_pad_with_zero_i
);

  bda_pkg::bda_cmd_t    cmd;
  bda_pkg::bda_status_t status;
  logic                 pad_with_zero_q;

  // pad register: space when 0, ASCII zero when 1
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_with_zero_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      pad_with_zero_q <= cfg_pad_with_zero_i;
    end
  end

  bda_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  bda_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .value_i         (value_i),
    .digit_count_i   (digit_count_i),
    .pad_with_zero_i (pad_with_zero_q),
    .status_o        (status),
    .char_valid_o    (char_valid_o),
    .char_code_o     (char_code_o),
    .last_o          (last_o),
    .overflow_o      (overflow_o)
  );

endmodule

@@ rtl/core/bda_checker.sv @@
// bda_checker: port-level assertions for binary_to_decimal_ascii_top, and its bind.
// Depends on bda_pkg.
module bda_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_o,
  input logic                         char_valid_o,
  input logic [bda_pkg::CHAR_W-1:0]   char_code_o,
  input logic                         last_o,
  input logic                         overflow_o
);

  // an accepted transaction makes the block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy not raised after accepted transaction");

  // characters of one transaction come back to back
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_valid_o && !last_o |=> char_valid_o)
    else $error("gap inside a character burst");

  // no character right after the last one
  a_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_valid_o && last_o |=> !char_valid_o)
    else $error("character right after last");

  // overflow is one flag for the whole transaction
  a_ovf_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_valid_o && !last_o |=> $stable(overflow_o))
    else $error("overflow changed within a transaction");

  // only digits or a space are emitted
  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_valid_o |-> (char_code_o == bda_pkg::CH_SPACE) ||
                     ((char_code_o >= bda_pkg::CH_ZERO) &&
                      (char_code_o <= bda_pkg::CH_ZERO + 8'd9)))
    else $error("illegal character code");

endmodule

bind binary_to_decimal_ascii_top bda_checker u_bda_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .char_valid_o (char_valid_o),
  .char_code_o  (char_code_o),
  .last_o       (last_o),
  .overflow_o   (overflow_o)
);

@@ dv/bda_ascii_checker.sv @@
// bda_ascii_checker: watches the command, result and config channels of the
// binary to decimal ASCII converter, predicts every character and compares it.
// Depends on bda_pkg for widths and character codes.
module bda_ascii_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_o,
  input  logic [bda_pkg::BIN_W-1:0]  value_i,
  input  logic [bda_pkg::CNT_W-1:0]  digit_count_i,
  input  logic                       char_valid_o,
  input  logic [bda_pkg::CHAR_W-1:0] char_code_o,
  input  logic                       last_o,
  input  logic                       overflow_o,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_o,
  input  logic                       cfg_pad_with_zero_i,
  output int                         mismatch_count,
  output int                         chars_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [bda_pkg::CHAR_W-1:0] code;
    logic                       last;
    logic                       ovf;
  } ascii_char_t;

  ascii_char_t expected_chars[$];
  logic        pad_zero;

  // Build the character string for one conversion and queue it.
  function automatic void predict_digits(input logic [bda_pkg::BIN_W-1:0] val,
                                         input logic [bda_pkg::CNT_W-1:0] cnt);
    logic [3:0]                dig [bda_pkg::DEC_DIGITS];
    logic [bda_pkg::BIN_W-1:0] rem;
    int                        top_pos;
    int                        width;
    int                        pos;
    int                        i;
    bit                        fixed_w;
    bit                        ovf;
    ascii_char_t               c;
    rem     = val;
    top_pos = 0;
    for (i = 0; i < bda_pkg::DEC_DIGITS; i++) begin
      dig[i] = 4'(rem % 10);
      rem    = rem / 10;
      if (dig[i] != 0) top_pos = i;
    end
    fixed_w = (cnt != 0);
    ovf     = 1'b0;
    if (fixed_w) begin
      width = (int'(cnt) > bda_pkg::USABLE) ? bda_pkg::USABLE : int'(cnt);
      ovf   = (top_pos >= width);
    end else begin
      width = top_pos + 1;
      if (width > bda_pkg::USABLE) begin
        width = bda_pkg::USABLE;
        ovf   = 1'b1;
      end
    end
    for (i = 0; i < width; i++) begin
      pos = width - 1 - i;
      // leading zeros become pad; the units digit is always a digit
      if (fixed_w && pos > top_pos && pos > 0)
        c.code = pad_zero ? bda_pkg::CH_ZERO : bda_pkg::CH_SPACE;
      else
        c.code = bda_pkg::CH_ZERO + bda_pkg::CHAR_W'(dig[pos]);
      c.last = (i == width - 1);
      c.ovf  = ovf;
      expected_chars.push_back(c);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ascii_char_t exp_c;
    if (!rst_ni) begin
      pad_zero       = 1'b0;
      mismatch_count = 0;
      expected_chars.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) pad_zero = cfg_pad_with_zero_i;
      // characters first: one arriving with a new command belongs to the old one
      if (char_valid_o) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character: char_code %0d last %0b overflow %0b",
                 char_code_o, last_o, overflow_o);
          mismatch_count++;
        end else begin
          exp_c = expected_chars.pop_front();
          if (char_code_o !== exp_c.code) begin
            $error("char_code: expected %0d, actual %0d", exp_c.code, char_code_o);
            mismatch_count++;
          end
          if (last_o !== exp_c.last) begin
            $error("last: expected %0b, actual %0b", exp_c.last, last_o);
            mismatch_count++;
          end
          if (overflow_o !== exp_c.ovf) begin
            $error("overflow: expected %0b, actual %0b", exp_c.ovf, overflow_o);
            mismatch_count++;
          end
        end
      end
      if (start_i && !busy_o) predict_digits(value_i, digit_count_i);
    end
    chars_pending = expected_chars.size();
  end

endmodule

@@ dv/tb_binary_to_decimal_ascii_top.sv @@
// tb_binary_to_decimal_ascii_top: stimulus and verdict for binary_to_decimal_ascii_top.
// Depends on bda_pkg, the RTL top and bda_ascii_checker, which checks every character.
module tb_binary_to_decimal_ascii_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Conversions and sender gaps (at most MAX_GAP) are far shorter than
  // STALL_LIMIT, so that many quiet cycles can only mean a hang.
  localparam int STALL_LIMIT     = 2000;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int MAX_GAP         = 45;
  localparam int TAIL_CYCLES     = 60;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start_i;
  logic                       busy_o;
  logic [bda_pkg::BIN_W-1:0]  value_i;
  logic [bda_pkg::CNT_W-1:0]  digit_count_i;
  logic                       char_valid_o;
  logic [bda_pkg::CHAR_W-1:0] char_code_o;
  logic                       last_o;
  logic                       overflow_o;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic                       cfg_pad_with_zero_i;

  int mismatch_count;
  int chars_pending;
  int sender_idle_pct;
  int quiet_cycles;

  binary_to_decimal_ascii_top dut (.*);

  bda_ascii_checker checker_i (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hang detector: any accepted transaction on any channel resets the count.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles = 0;
    end else begin
      if ((start_i && !busy_o) || char_valid_o || (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic logic [bda_pkg::BIN_W-1:0] pow10(input int k);
    logic [bda_pkg::BIN_W-1:0] p;
    p = 1;
    repeat (k) p = p * 10;
    return p;
  endfunction

  // Mix of full-range values, short numbers and decade edges (10^k, 10^k - 1),
  // where the digit count and the overflow decision flip.
  function automatic logic [bda_pkg::BIN_W-1:0] random_value();
    logic [bda_pkg::BIN_W-1:0] v;
    case ($urandom_range(4))
      0, 1: v = $urandom;
      2:    v = $urandom % pow10($urandom_range(1, 9));
      3:    v = pow10($urandom_range(0, 9)) - $urandom_range(0, 1);
      default: v = $urandom_range(0, 99);
    endcase
    return v;
  endfunction

  function automatic logic [bda_pkg::CNT_W-1:0] random_count();
    // counts above 10 saturate; keep them to about one in ten
    if ($urandom_range(9) == 0) return bda_pkg::CNT_W'($urandom_range(11, 15));
    return bda_pkg::CNT_W'($urandom_range(0, 10));
  endfunction

  // One command transaction. start_i stays high when the next one follows at
  // once, so it gets a single assignment per time step.
  task automatic send_cmd(input logic [bda_pkg::BIN_W-1:0] v,
                          input logic [bda_pkg::CNT_W-1:0] cnt);
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      // long enough gaps to land on any phase of a conversion
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk_i);
    end
    start_i       <= 1'b1;
    value_i       <= v;
    digit_count_i <= cnt;
    // busy only moves at the clock edge, so the negedge value decides acceptance
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
  endtask

  // Stop sending and wait until every predicted character has come out.
  task automatic drain_results();
    start_i <= 1'b0;
    do @(negedge clk_i); while (chars_pending != 0 || busy_o);
    @(posedge clk_i);
  endtask

  // Config transaction; only called with the converter drained.
  task automatic write_pad(input logic pad);
    cfg_valid_i         <= 1'b1;
    cfg_pad_with_zero_i <= pad;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random_phase(input int idle_pct);
    sender_idle_pct = idle_pct;
    repeat (ITEMS_PER_PHASE) send_cmd(random_value(), random_count());
  endtask

  initial begin
    rst_ni              = 1'b0;
    start_i             = 1'b0;
    value_i             = '0;
    digit_count_i       = '0;
    cfg_valid_i         = 1'b0;
    cfg_pad_with_zero_i = 1'b0;
    sender_idle_pct     = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, pad left at its reset value (space).
    send_cmd(32'd0, 4'd0);            // zero, minimal width: single '0'
    send_cmd(32'd0, 4'd5);            // zero, fixed width: pads then '0'
    send_cmd(32'd0, 4'd1);
    send_cmd(32'hFFFF_FFFF, 4'd0);    // largest value, all ten digits
    send_cmd(32'hFFFF_FFFF, 4'd10);
    send_cmd(32'hFFFF_FFFF, 4'd3);    // too wide for fixed width: low digits, overflow
    send_cmd(32'hFFFF_FFFF, 4'd15);   // count saturates at the usable width
    send_cmd(32'd1234567890, 4'd10);
    send_cmd(32'd1000000000, 4'd9);   // just too wide
    send_cmd(32'd999999999, 4'd9);    // just fits
    send_cmd(32'd7, 4'd1);
    send_cmd(32'd10, 4'd1);           // two digits into one
    send_cmd(32'd42, 4'd11);
    send_cmd(32'd42, 4'd12);
    send_cmd(32'd123, 4'd0);
    send_cmd(32'd1000, 4'd4);
    send_cmd(32'd5, 4'd15);
    send_cmd(32'd100, 4'd6);          // inner zeros stay digits
    drain_results();

    // Same corners with '0' as the pad.
    write_pad(1'b1);
    send_cmd(32'd0, 4'd5);
    send_cmd(32'd42, 4'd10);
    send_cmd(32'd0, 4'd0);
    send_cmd(32'd100, 4'd8);

    // Random phases: sender idles 22%, then 56%, then never. Each phase
    // boundary drains the converter fully before the pad is rewritten.
    run_random_phase(22);
    drain_results();
    write_pad(1'b0);
    run_random_phase(56);
    drain_results();
    write_pad(1'b1);
    run_random_phase(0);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (chars_pending != 0)
      $error("%0d expected characters never arrived", chars_pending);
    if (mismatch_count == 0 && chars_pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
